// File: design/dccg_pkg.sv
// shared types and constants for the dcc packet waveform generator
`default_nettype none

package dccg_pkg;

  localparam int MAX_PACKET_BYTES = 8;
  localparam int IDX_W            = $clog2(MAX_PACKET_BYTES);
  localparam int BYTES_W          = $clog2(MAX_PACKET_BYTES + 1);
  localparam int PERIOD_W         = 20;
  localparam int BITS_W           = 5;
  localparam int BYTE_BITS        = 8;

  localparam logic [PERIOD_W-1:0] ONE_HALF_RESET    = 20'd4640;
  localparam logic [PERIOD_W-1:0] ZERO_FIRST_RESET  = 20'd8000;
  localparam logic [PERIOD_W-1:0] ZERO_SECOND_RESET = 20'd8000;
  localparam logic [BITS_W-1:0]   PREAMBLE_RESET    = 5'd14;

  typedef enum logic [1:0] {
    KIND_EXPIRE = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_START  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_ONE_HALF    = 2'd0,
    CFG_ZERO_FIRST  = 2'd1,
    CFG_ZERO_SECOND = 2'd2,
    CFG_PREAMBLE    = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PREAMBLE = 3'd1,
    PH_BSTART   = 3'd2,
    PH_BYTE     = 3'd3,
    PH_END      = 3'd4
  } phase_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] one_half;
    logic [PERIOD_W-1:0] zero_first;
    logic [PERIOD_W-1:0] zero_second;
    logic [BITS_W-1:0]   preamble_len;
  } cfg_t;

  typedef struct packed {
    logic                track_level;
    logic [PERIOD_W-1:0] next_half_period;
    logic                busy;
    logic                start_rejected;
  } result_t;

endpackage

`default_nettype wire

// File: design/dccg_bit_engine.sv
// bit phase machine, packet store and result logic for one beat
`default_nettype none

module dccg_bit_engine (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     step,
  input  wire logic [1:0]               kind,
  input  wire logic [2:0]               byte_index,
  input  wire logic [7:0]               byte_value,
  input  wire logic [3:0]               packet_bytes,
  input  wire dccg_pkg::cfg_t           cfg,
  output dccg_pkg::result_t             result
);
  import dccg_pkg::*;

  phase_t                phase, phase_next;
  logic                  pin_level, pin_level_next;
  logic [PERIOD_W-1:0]   current_count, current_count_next;
  logic [BITS_W-1:0]     bits_left, bits_left_next;
  logic [BYTES_W-1:0]    bytes_left, bytes_left_next;
  logic [BYTES_W-1:0]    packet_length, packet_length_next;
  logic                  rejected;
  logic [7:0]            packet_store [MAX_PACKET_BYTES];
  logic [7:0]            cur_byte;
  logic [2:0]            bit_sel;
  logic [BITS_W-1:0]     bits_dec;
  logic [BYTES_W-1:0]    bytes_dec;
  logic                  store_we;

  // byte being serialized and its current bit
  assign cur_byte = packet_store[IDX_W'(packet_length - bytes_left)];
  assign bit_sel  = bits_left[2:0] - 3'd1;
  assign bits_dec = bits_left - BITS_W'(1);
  assign bytes_dec = bytes_left - BYTES_W'(1);
  assign store_we = step && (kind_t'(kind) == KIND_WRITE) &&
                    (int'(byte_index) < MAX_PACKET_BYTES);

  // next state
  always_comb begin
    phase_next         = phase;
    pin_level_next     = pin_level;
    current_count_next = current_count;
    bits_left_next     = bits_left;
    bytes_left_next    = bytes_left;
    packet_length_next = packet_length;
    rejected           = 1'b0;
    case (kind)
      KIND_EXPIRE: begin
        if (!pin_level) begin
          if (current_count == cfg.zero_first) current_count_next = cfg.zero_second;
          pin_level_next = 1'b1;
        end else begin
          pin_level_next = 1'b0;
          unique case (phase)
            PH_IDLE: begin
              current_count_next = cfg.one_half;
              if (bytes_left != '0) begin
                bits_left_next = bits_dec;
                phase_next = (bits_dec == '0) ? PH_BSTART : PH_PREAMBLE;
              end
            end
            PH_PREAMBLE: begin
              current_count_next = cfg.one_half;
              bits_left_next     = bits_dec;
              if (bits_dec == '0) phase_next = PH_BSTART;
            end
            PH_BSTART: begin
              current_count_next = cfg.zero_first;
              phase_next         = PH_BYTE;
              bits_left_next     = BITS_W'(BYTE_BITS);
            end
            PH_BYTE: begin
              current_count_next = cur_byte[bit_sel] ? cfg.one_half : cfg.zero_first;
              bits_left_next     = bits_dec;
              if (bits_dec == '0) begin
                bytes_left_next = bytes_dec;
                phase_next = (bytes_dec == '0) ? PH_END : PH_BSTART;
              end
            end
            default: begin
              current_count_next = cfg.one_half;
              phase_next         = PH_IDLE;
              bits_left_next     = cfg.preamble_len;
            end
          endcase
        end
      end
      KIND_START: begin
        if (bytes_left != '0) begin
          rejected = 1'b1;
        end else if (packet_bytes != 4'd0) begin
          if (int'(packet_bytes) > MAX_PACKET_BYTES) begin
            packet_length_next = BYTES_W'(MAX_PACKET_BYTES);
          end else begin
            packet_length_next = BYTES_W'(packet_bytes);
          end
          bytes_left_next = packet_length_next;
        end
      end
      default: begin
      end
    endcase
  end

  // result of this beat
  always_comb begin
    result.track_level      = pin_level_next;
    result.next_half_period = current_count_next;
    result.busy             = (bytes_left_next != '0);
    result.start_rejected   = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      pin_level     <= 1'b0;
      current_count <= ONE_HALF_RESET;
      bits_left     <= PREAMBLE_RESET;
      bytes_left    <= '0;
      packet_length <= '0;
    end else if (step) begin
      phase         <= phase_next;
      pin_level     <= pin_level_next;
      current_count <= current_count_next;
      bits_left     <= bits_left_next;
      bytes_left    <= bytes_left_next;
      packet_length <= packet_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      packet_store[IDX_W'(byte_index)] <= byte_value;
    end
  end

endmodule

`default_nettype wire

// File: design/dcc_packet_waveform_generator.sv
// a result beat is registered and shown in the cycle after its input beat is accepted
// throughput: one beat per cycle while out_ready is high; the output register accepts a new beat
// in the same cycle its held beat is taken
// reset: rst is synchronous and clears the phase machine, pin level,
// counters and timing registers to their defaults; packet store is not cleared
`default_nettype none

module dcc_packet_waveform_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [2:0]  byte_index,
  input  wire logic [7:0]  byte_value,
  input  wire logic [3:0]  packet_bytes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             track_level,
  output logic [19:0]      next_half_period,
  output logic             busy_res,
  output logic             start_rejected
);
  import dccg_pkg::*;

  cfg_t    cfg;
  result_t beat_result;
  result_t out_reg;
  logic    step;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_half     <= ONE_HALF_RESET;
      cfg.zero_first   <= ZERO_FIRST_RESET;
      cfg.zero_second  <= ZERO_SECOND_RESET;
      cfg.preamble_len <= PREAMBLE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ONE_HALF:    cfg.one_half     <= cfg_data;
        CFG_ZERO_FIRST:  cfg.zero_first   <= cfg_data;
        CFG_ZERO_SECOND: cfg.zero_second  <= cfg_data;
        CFG_PREAMBLE:    cfg.preamble_len <= cfg_data[BITS_W-1:0];
      endcase
    end
  end

  dccg_bit_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .kind         (kind),
    .byte_index   (byte_index),
    .byte_value   (byte_value),
    .packet_bytes (packet_bytes),
    .cfg          (cfg),
    .result       (beat_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reg <= beat_result;
    end
  end

  assign track_level      = out_reg.track_level;
  assign next_half_period = out_reg.next_half_period;
  assign busy_res         = out_reg.busy;
  assign start_rejected   = out_reg.start_rejected;

endmodule

`default_nettype wire
